// ----- hw/rtl/iokv_pkg.sv -----
// Shared types and constants for the insertion-ordered key/value table.
// Holds the command codes, the transaction payload structs and the cell control struct.
// No dependencies.
package iokv_pkg;

    localparam int FIELD_W     = 32;
    localparam int CAP_W       = 5;
    localparam int COUNT_OUT_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               command;
        logic [FIELD_W-1:0] lookup_key;
        logic [FIELD_W-1:0] new_value;
    } t_in;

    typedef struct packed {
        logic                   hit;
        logic [FIELD_W-1:0]     result_value;
        logic                   evicted;
        logic [FIELD_W-1:0]     evicted_key;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_out;

    typedef struct packed {
        logic live;
        logic shift;
        logic load;
        logic upd;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/iokv_cell.sv -----
// One slot of the table chain: a key/value register pair with its own key compare.
// Takes its neighbor's contents on a shift, the new pair on a load, or only the new value on an update.
// Depends on iokv_pkg.
module iokv_cell #(
    parameter int KW = 32,
    parameter int VW = 32
) (
    input  logic                 i_clk,
    input  iokv_pkg::t_cell_ctl  i_ctl,
    input  logic [KW-1:0]        i_key,
    input  logic [VW-1:0]        i_value,
    input  logic [KW-1:0]        i_next_key,
    input  logic [VW-1:0]        i_next_value,
    output logic [KW-1:0]        o_key,
    output logic [VW-1:0]        o_value,
    output logic                 o_match
);
    import iokv_pkg::*;

    logic [KW-1:0] r_key;
    logic [VW-1:0] r_value;
    logic [KW-1:0] n_key;
    logic [VW-1:0] n_value;

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        if (i_ctl.load) begin
            n_key   = i_key;
            n_value = i_value;
        end else if (i_ctl.shift) begin
            n_key   = i_next_key;
            n_value = i_next_value;
        end else if (i_ctl.upd) begin
            n_value = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_match = i_ctl.live && (r_key == i_key);

endmodule

// ----- hw/rtl/insertion_ordered_key_value_table.sv -----
// Top level of the insertion-ordered key/value table: a chain of iokv_cell slots,
// the entry count, the capacity register and the result register.
// Depends on iokv_pkg and iokv_cell.
//
// Usage:
// Commands enter on the input channel (i_in_valid / o_in_ready) and each one gives
// exactly one result transaction on the output channel (o_out_valid / i_out_ready).
// All slots compare the key in parallel, and the chain updates, appends or shifts
// by one slot in the same cycle that a command is accepted.
// The result is registered: it appears in the cycle after acceptance, and one command
// is taken per cycle as long as the receiver keeps taking results.
// When the receiver stalls, the result register holds its transaction and the input
// is accepted again in the cycle in which that transaction is taken.
// The user must write the capacity register (i_cfg_we / i_cfg_data) only while the
// block is idle; the block itself does not enforce this. Reset empties the table, sets
// the capacity to 16 and drops any pending result; keys and values are not cleared.
module insertion_ordered_key_value_table #(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  iokv_pkg::t_in                i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output iokv_pkg::t_out               o_out_data,
    input  logic                         i_cfg_we,
    input  logic [iokv_pkg::CAP_W-1:0]   i_cfg_data
);
    import iokv_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    logic [CAP_W-1:0] r_cap;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_out_valid;
    t_out             r_out;
    t_out             n_out;

    logic [KEY_WIDTH-1:0]   w_key_in;
    logic [VALUE_WIDTH-1:0] w_val_in;
    logic [KEY_WIDTH-1:0]   w_key   [DEPTH];
    logic [VALUE_WIDTH-1:0] w_val   [DEPTH];
    logic [DEPTH-1:0]       w_match;
    t_cell_ctl              w_ctl   [DEPTH];

    logic                   w_accept;
    logic                   w_hit;
    logic [IW-1:0]          w_slot;
    logic [VALUE_WIDTH-1:0] w_hit_val;
    logic [EW-1:0]          w_cap_eff;
    logic                   w_full;
    logic [CW-1:0]          w_count_m1;
    logic                   w_put;
    logic                   w_put_miss;
    logic                   w_evict;
    logic                   w_rem_hit;

    assign w_key_in   = KEY_WIDTH'(i_in_data.lookup_key);
    assign w_val_in   = VALUE_WIDTH'(i_in_data.new_value);
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [KEY_WIDTH-1:0]   w_nk;
            logic [VALUE_WIDTH-1:0] w_nv;
            if (g < DEPTH - 1) begin : g_mid
                assign w_nk = w_key[g+1];
                assign w_nv = w_val[g+1];
            end else begin : g_end
                assign w_nk = '0;
                assign w_nv = '0;
            end
            iokv_cell #(
                .KW (KEY_WIDTH),
                .VW (VALUE_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl[g]),
                .i_key        (w_key_in),
                .i_value      (w_val_in),
                .i_next_key   (w_nk),
                .i_next_value (w_nv),
                .o_key        (w_key[g]),
                .o_value      (w_val[g]),
                .o_match      (w_match[g])
            );
        end
    endgenerate

    always_comb begin
        w_slot    = '0;
        w_hit_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_match[i]) begin
                w_slot    = w_slot | IW'(i);
                w_hit_val = w_hit_val | w_val[i];
            end
        end
    end

    assign w_hit = |w_match;

    always_comb begin
        if (r_cap == '0) begin
            w_cap_eff = EW'(1);
        end else if (EW'(r_cap) > EW'(DEPTH)) begin
            w_cap_eff = EW'(DEPTH);
        end else begin
            w_cap_eff = EW'(r_cap);
        end
    end

    assign w_full     = EW'(r_count) >= w_cap_eff;
    assign w_count_m1 = r_count - CW'(1);
    assign w_put      = w_accept && (i_in_data.command == CMD_PUT);
    assign w_put_miss = w_put && !w_hit;
    assign w_evict    = w_put_miss && w_full;
    assign w_rem_hit  = w_accept && (i_in_data.command == CMD_REMOVE) && w_hit;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ctl[i].live  = CW'(i) < r_count;
            w_ctl[i].load  = w_put_miss &&
                             ((!w_full && CW'(i) == r_count) ||
                              (w_full && CW'(i) == w_count_m1));
            w_ctl[i].shift = (w_evict && CW'(i) < w_count_m1) ||
                             (w_rem_hit && IW'(i) >= w_slot && CW'(i) < w_count_m1);
            w_ctl[i].upd   = w_put && w_match[i];
        end
    end

    always_comb begin
        n_count = r_count;
        n_out   = '0;
        unique case (i_in_data.command)
            CMD_PUT: begin
                if (w_hit) begin
                    n_out.hit          = 1'b1;
                    n_out.result_value = FIELD_W'(w_hit_val);
                end else if (w_full) begin
                    n_out.evicted      = 1'b1;
                    n_out.evicted_key  = FIELD_W'(w_key[0]);
                    n_out.result_value = FIELD_W'(w_val[0]);
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            CMD_LOOKUP: begin
                n_out.hit          = w_hit;
                n_out.result_value = w_hit ? FIELD_W'(w_hit_val) : '0;
            end
            CMD_REMOVE: begin
                n_out.hit = w_hit;
                if (w_hit) begin
                    n_count = w_count_m1;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.entry_count = COUNT_OUT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_unique_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid |-> $onehot0(w_match))
        else $error("More than one live slot matches the key.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_evict_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.evicted) |-> !o_out_data.hit)
        else $error("Eviction reported together with a hit.");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.command == CMD_CLEAR) |=> (r_count == '0))
        else $error("Clear transaction left entries in the table.");

    a_evict_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_evict |=> (r_count == $past(r_count)))
        else $error("Eviction changed the entry count.");

endmodule

// ----- dv/tb_insertion_ordered_key_value_table.sv -----
// Self-checking testbench for insertion_ordered_key_value_table: a clocked driver and monitor,
// a table predictor kept in step with every accepted command, and several capacity settings.
// Depends on iokv_pkg and the insertion_ordered_key_value_table RTL.
module tb_insertion_ordered_key_value_table;
    import iokv_pkg::*;

    localparam int TBL_DEPTH = 16;

    localparam int RX_FREE     = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_MOSTLY   = 3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;
    logic i_cfg_we = 1'b0;
    logic [CAP_W-1:0] i_cfg_data = '0;

    insertion_ordered_key_value_table dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    // Mirror of the table contents and the capacity register.
    logic [FIELD_W-1:0] tbl_key [TBL_DEPTH];
    logic [FIELD_W-1:0] tbl_val [TBL_DEPTH];
    int tbl_count = 0;
    logic [CAP_W-1:0] cfg_capacity = CAP_RESET;

    t_in cmd_queue [$];
    t_out expected_outcomes [$];
    logic [FIELD_W-1:0] key_pool [$];
    int error_count = 0;
    bit in_taken = 1'b0;
    int hold_seq = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out table_apply(t_in c);
        t_out r;
        int slot;
        int eff;
        int last;
        r = '0;
        slot = -1;
        eff = (cfg_capacity == 0) ? 1 : (cfg_capacity > TBL_DEPTH) ? TBL_DEPTH : cfg_capacity;
        for (int i = 0; i < tbl_count; i++) begin
            if (slot < 0 && tbl_key[i] == c.lookup_key) slot = i;
        end
        case (c.command)
            CMD_PUT: begin
                if (slot >= 0) begin
                    r.hit = 1'b1;
                    r.result_value = tbl_val[slot];
                    tbl_val[slot] = c.new_value;
                end else if (tbl_count < eff) begin
                    tbl_key[tbl_count] = c.lookup_key;
                    tbl_val[tbl_count] = c.new_value;
                    tbl_count++;
                end else begin
                    last = tbl_count - 1;
                    r.evicted = 1'b1;
                    r.evicted_key = tbl_key[0];
                    r.result_value = tbl_val[0];
                    for (int i = 0; i < last; i++) begin
                        tbl_key[i] = tbl_key[i + 1];
                        tbl_val[i] = tbl_val[i + 1];
                    end
                    tbl_key[last] = c.lookup_key;
                    tbl_val[last] = c.new_value;
                end
            end
            CMD_LOOKUP: begin
                if (slot >= 0) begin
                    r.hit = 1'b1;
                    r.result_value = tbl_val[slot];
                end
            end
            CMD_REMOVE: begin
                if (slot >= 0) begin
                    r.hit = 1'b1;
                    for (int i = slot; i < tbl_count - 1; i++) begin
                        tbl_key[i] = tbl_key[i + 1];
                        tbl_val[i] = tbl_val[i + 1];
                    end
                    tbl_count--;
                end
            end
            default: begin
                tbl_count = 0;
            end
        endcase
        r.entry_count = tbl_count[COUNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic compare_field(string name, logic [FIELD_W-1:0] exp_v,
                                 logic [FIELD_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
            error_count++;
        end
    endtask

    // Monitor: predicts on every accepted command and checks every accepted result.
    always @(posedge i_clk) begin : monitor_proc
        t_out exp_r;
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_cfg_we) cfg_capacity = i_cfg_data;
            if (o_out_valid && i_out_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: result transaction with none expected, actual %p",
                             $time, o_out_data);
                    error_count++;
                end else begin
                    exp_r = expected_outcomes.pop_front();
                    compare_field("hit", FIELD_W'(exp_r.hit), FIELD_W'(o_out_data.hit));
                    compare_field("result_value", exp_r.result_value, o_out_data.result_value);
                    compare_field("evicted", FIELD_W'(exp_r.evicted),
                                  FIELD_W'(o_out_data.evicted));
                    compare_field("evicted_key", exp_r.evicted_key, o_out_data.evicted_key);
                    compare_field("entry_count", FIELD_W'(exp_r.entry_count),
                                  FIELD_W'(o_out_data.entry_count));
                end
            end
            if (in_taken) begin
                exp_r = table_apply(i_in_data);
                expected_outcomes.insert(expected_outcomes.size(), exp_r);
            end
        end
    end

    // Driver: bursts of commands with random gaps, one transaction per accept.
    always @(negedge i_clk) begin : driver_proc
        t_in nxt;
        logic nv;
        int burst_left;
        int gap_left;
        nxt = i_in_data;
        nv = i_in_valid;
        if (!i_rst_n) begin
            nv = 1'b0;
            burst_left = 1;
            gap_left = 0;
        end else if (!i_in_valid || in_taken) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_queue.size() > 0) begin
                nxt = cmd_queue.pop_front();
                nv = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else if ($urandom_range(0, 3) == 0) begin
                    burst_left = $urandom_range(30, 80);
                    gap_left = 0;
                end else begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = $urandom_range(0, 6);
                end
            end
        end
        i_in_valid <= nv;
        i_in_data <= nxt;
    end

    // Receiver: stall patterns that change every segment, plus long holds on request.
    always @(negedge i_clk) begin : sink_proc
        logic rdy;
        int hold_seen;
        int hold_left;
        int seg_left;
        int rx_mode;
        int rx_k;
        int rx_tick;
        rdy = 1'b1;
        if (!i_rst_n) begin
            rdy = 1'b0;
            hold_seen = 0;
            hold_left = 0;
            seg_left = 0;
            rx_tick = 0;
        end else if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = 150;
            rdy = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else begin
            if (seg_left == 0) begin
                rx_mode = $urandom_range(RX_FREE, RX_MOSTLY);
                seg_left = $urandom_range(10, 60);
                rx_k = $urandom_range(2, 4);
            end
            seg_left--;
            rx_tick++;
            case (rx_mode)
                RX_FREE: rdy = 1'b1;
                RX_COIN: rdy = 1'($urandom_range(0, 1));
                RX_PERIODIC: rdy = (rx_tick % rx_k) == 0;
                default: rdy = $urandom_range(0, 4) != 0;
            endcase
        end
        i_out_ready <= rdy;
    end

    task automatic push_cmd(t_cmd c, logic [FIELD_W-1:0] k, logic [FIELD_W-1:0] v);
        t_in item;
        item.command = c;
        item.lookup_key = k;
        item.new_value = v;
        cmd_queue.insert(cmd_queue.size(), item);
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() != 0 || i_in_valid || expected_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= cap;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_random(int n, int eff_cap);
        int pool_n;
        int pick;
        logic [FIELD_W-1:0] k;
        t_cmd c;
        key_pool.delete();
        key_pool.insert(key_pool.size(), '0);
        key_pool.insert(key_pool.size(), '1);
        pool_n = eff_cap + $urandom_range(1, 8);
        for (int i = 0; i < pool_n; i++) key_pool.insert(key_pool.size(), $urandom);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 48) c = CMD_PUT;
            else if (pick < 78) c = CMD_LOOKUP;
            else if (pick < 97) c = CMD_REMOVE;
            else c = CMD_CLEAR;
            if ($urandom_range(0, 19) == 0) k = $urandom;
            else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            push_cmd(c, k, $urandom);
        end
    endtask

    initial begin : stimulus_proc
        int caps [10];
        int eff;
        caps = '{31, 2, 16, 5, 1, 17, 8, 0, 12, 16};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_cmd(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        push_cmd(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        push_cmd(CMD_PUT, 32'h1234_5678, 32'hA5A5_A5A5);
        push_cmd(CMD_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
        push_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(CMD_LOOKUP, 32'h0000_0001, 32'h0);
        push_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0);
        wait_idle();

        // The count stays above the capacity, so each put miss evicts in place.
        write_capacity(5'd1);
        push_cmd(CMD_PUT, 32'h0000_0009, 32'h0000_0001);
        push_cmd(CMD_PUT, 32'h1234_5678, 32'h0000_0002);
        push_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
        push_cmd(CMD_REMOVE, 32'h0000_0077, 32'h0);
        push_cmd(CMD_REMOVE, 32'h0000_0000, 32'h0);
        push_cmd(CMD_PUT, 32'h0000_0000, 32'h0000_0003);
        push_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0);
        wait_idle();

        // A capacity of zero behaves as one.
        write_capacity(5'd0);
        push_cmd(CMD_PUT, 32'h0000_0004, 32'h0000_0004);
        push_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(CMD_LOOKUP, 32'h0000_0009, 32'h0);
        push_cmd(CMD_REMOVE, 32'h0000_0009, 32'h0);
        push_cmd(CMD_PUT, 32'h0000_0006, 32'h0000_0006);
        push_cmd(CMD_PUT, 32'h0000_0007, 32'h0000_0007);
        wait_idle();

        foreach (caps[p]) begin
            write_capacity(caps[p][CAP_W-1:0]);
            eff = (caps[p] == 0) ? 1 : (caps[p] > TBL_DEPTH) ? TBL_DEPTH : caps[p];
            queue_random(150, eff);
            if (p == 2 || p == 6) hold_seq++;
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_outcomes.size() == 0) begin
            $display("insertion_ordered_key_value_table verification clean");
        end else begin
            $display("insertion_ordered_key_value_table verification failed");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #3000000;
        $display("insertion_ordered_key_value_table verification failed");
        $finish;
    end

endmodule
